[rtl/pflr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pflr_pkg;

   localparam int DEFAULT_SCREEN_WIDTH  = 128;
   localparam int DEFAULT_SCREEN_HEIGHT = 64;

   localparam int COORD_W = 16;
   localparam int DATA_W  = 8;
   localparam int ERR_W   = 20;

   localparam logic [1:0] KIND_LINE = 2'd0;
   localparam logic [1:0] KIND_RECT = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   localparam logic [1:0] PEN_SET   = 2'd0;
   localparam logic [1:0] PEN_CLEAR = 2'd1;
   localparam logic [1:0] PEN_FLIP  = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LINE_PRIME,
      ST_LINE,
      ST_LINE_WR,
      ST_RECT_SETUP,
      ST_RECT,
      ST_RECT_WR,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic prime;
      logic step;
   } line_ctl_type;

   function automatic logic [DATA_W-1:0] apply_pen(input logic [DATA_W-1:0] data,
                                                   input logic [DATA_W-1:0] mask,
                                                   input logic [1:0]        pen);
      logic [DATA_W-1:0] result;
      case (pen)
         PEN_SET:   result = data | mask;
         PEN_CLEAR: result = data & ~mask;
         PEN_FLIP:  result = data ^ mask;
         default:   result = data;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

[rtl/page_framebuffer_line_rect_engine_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// After reset the store is cleared one byte per cycle with busy high; commands are
// taken once busy falls. A line reads and writes one store byte for each on-screen
// pixel and steps past off-screen pixels; a rectangle reads and writes each covered
// byte; a read reads one byte. The result word is strobed in the last state and busy
// falls in the next; the receiver cannot stall.
module page_framebuffer_line_rect_engine_unit #(
   parameter int SCREEN_WIDTH  = pflr_pkg::DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = pflr_pkg::DEFAULT_SCREEN_HEIGHT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic        [1:0]                     req_kind,
   input  wire logic signed [pflr_pkg::COORD_W-1:0]   req_x_a,
   input  wire logic signed [pflr_pkg::COORD_W-1:0]   req_y_a,
   input  wire logic signed [pflr_pkg::COORD_W-1:0]   req_x_b,
   input  wire logic signed [pflr_pkg::COORD_W-1:0]   req_y_b,
   input  wire logic        [1:0]                     req_pen,
   output logic                                       rsp_valid,
   output logic             [pflr_pkg::DATA_W-1:0]    rsp_read_data
);

   localparam int CW          = pflr_pkg::COORD_W;
   localparam int DW          = pflr_pkg::DATA_W;
   localparam int BW          = CW + 2;
   localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int COL_W       = $clog2(SCREEN_WIDTH);
   localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int ROW_W       = PAGE_W + 3;

   localparam logic signed [CW-1:0] WIDTH_C  = CW'(SCREEN_WIDTH);
   localparam logic signed [CW-1:0] HEIGHT_C = CW'(SCREEN_HEIGHT);
   localparam logic signed [CW-1:0] PAGES_C  = CW'(PAGE_COUNT);
   localparam logic signed [BW-1:0] X_MAX    = BW'(SCREEN_WIDTH - 1);
   localparam logic signed [BW-1:0] Y_MAX    = BW'(SCREEN_HEIGHT - 1);
   localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
   localparam logic [ADDR_W-1:0]    ROW_STEP  = ADDR_W'(SCREEN_WIDTH);

   pflr_pkg::state_type state_ff, state_in;

   logic        [1:0]        kind_ff, kind_in, pen_ff, pen_in;
   logic signed [CW-1:0]     xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   logic        [ADDR_W-1:0] clr_ff, clr_in;
   logic        [COL_W-1:0]  col_lo_ff, col_lo_in, col_hi_ff, col_hi_in, col_ff, col_in;
   logic        [ROW_W-1:0]  row_lo_ff, row_lo_in, row_hi_ff, row_hi_in;
   logic        [PAGE_W-1:0] page_ff, page_in;

   pflr_pkg::line_ctl_type line_ctl;
   logic signed [CW-1:0]   cur_x, cur_y;
   logic                   line_last, line_on;
   logic [ADDR_W-1:0]      line_addr, rect_addr, read_addr, mem_addr;
   logic [DW-1:0]          line_mask, rect_mask, mem_wdata, mem_rdata;
   logic                   mem_rd, mem_wr;
   logic                   read_ok, rect_empty, rect_end;
   logic [2:0]             lo_bit, hi_bit;

   logic signed [BW-1:0]   xa_w, ya_w, x_lo, x_hi, y_lo, y_hi, x_hi_full, y_hi_full;

   pflr_line_step u_line (
      .clock (clock),
      .ctl   (line_ctl),
      .x_a   (req_x_a),
      .y_a   (req_y_a),
      .x_b   (req_x_b),
      .y_b   (req_y_b),
      .cur_x (cur_x),
      .cur_y (cur_y),
      .last  (line_last)
   );

   pflr_store #(
      .DEPTH  (STORE_BYTES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .rd_en   (mem_rd),
      .wr_en   (mem_wr),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   always_comb begin
      line_on   = !cur_x[CW-1] && (cur_x < WIDTH_C) && !cur_y[CW-1] && (cur_y < HEIGHT_C);
      line_addr = ADDR_W'(ADDR_W'(cur_y[ROW_W-1:3]) * ROW_STEP) + ADDR_W'(cur_x[COL_W-1:0]);
      line_mask = DW'(1) << cur_y[2:0];

      xa_w      = $signed({{2{xa_ff[CW-1]}}, xa_ff});
      ya_w      = $signed({{2{ya_ff[CW-1]}}, ya_ff});
      x_hi_full = xa_w + $signed({{2{xb_ff[CW-1]}}, xb_ff}) - BW'(1);
      y_hi_full = ya_w + $signed({{2{yb_ff[CW-1]}}, yb_ff}) - BW'(1);
      x_lo      = xa_ff[CW-1] ? '0 : xa_w;
      y_lo      = ya_ff[CW-1] ? '0 : ya_w;
      x_hi      = (x_hi_full > X_MAX) ? X_MAX : x_hi_full;
      y_hi      = (y_hi_full > Y_MAX) ? Y_MAX : y_hi_full;
      rect_empty = (x_lo > x_hi) || (y_lo > y_hi);

      lo_bit    = (page_ff == row_lo_ff[ROW_W-1:3]) ? row_lo_ff[2:0] : 3'd0;
      hi_bit    = (page_ff == row_hi_ff[ROW_W-1:3]) ? row_hi_ff[2:0] : 3'd7;
      rect_mask = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
      rect_addr = ADDR_W'(ADDR_W'(page_ff) * ROW_STEP) + ADDR_W'(col_ff);
      rect_end  = (col_ff == col_hi_ff) && (page_ff == row_hi_ff[ROW_W-1:3]);

      read_ok   = !xa_ff[CW-1] && (xa_ff < WIDTH_C) && !ya_ff[CW-1] && (ya_ff < PAGES_C);
      read_addr = ADDR_W'(ADDR_W'(ya_ff[PAGE_W-1:0]) * ROW_STEP) + ADDR_W'(xa_ff[COL_W-1:0]);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pflr_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = pflr_pkg::ST_IDLE;
            end
         end
         pflr_pkg::ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  pflr_pkg::KIND_LINE: state_in = pflr_pkg::ST_LINE_PRIME;
                  pflr_pkg::KIND_RECT: state_in = pflr_pkg::ST_RECT_SETUP;
                  pflr_pkg::KIND_READ: state_in = pflr_pkg::ST_READ;
                  default:             state_in = pflr_pkg::ST_RESP;
               endcase
            end
         end
         pflr_pkg::ST_LINE_PRIME: state_in = pflr_pkg::ST_LINE;
         pflr_pkg::ST_LINE: begin
            if (line_on) begin
               state_in = pflr_pkg::ST_LINE_WR;
            end else if (line_last) begin
               state_in = pflr_pkg::ST_RESP;
            end
         end
         pflr_pkg::ST_LINE_WR: begin
            state_in = line_last ? pflr_pkg::ST_RESP : pflr_pkg::ST_LINE;
         end
         pflr_pkg::ST_RECT_SETUP: begin
            state_in = rect_empty ? pflr_pkg::ST_RESP : pflr_pkg::ST_RECT;
         end
         pflr_pkg::ST_RECT:    state_in = pflr_pkg::ST_RECT_WR;
         pflr_pkg::ST_RECT_WR: begin
            state_in = rect_end ? pflr_pkg::ST_RESP : pflr_pkg::ST_RECT;
         end
         pflr_pkg::ST_READ: state_in = pflr_pkg::ST_RESP;
         pflr_pkg::ST_RESP: state_in = pflr_pkg::ST_IDLE;
         default:           state_in = pflr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy          = 1'b1;
      rsp_valid     = 1'b0;
      rsp_read_data = '0;
      mem_rd        = 1'b0;
      mem_wr        = 1'b0;
      mem_addr      = line_addr;
      mem_wdata     = '0;
      line_ctl      = '0;
      case (state_ff)
         pflr_pkg::ST_CLEAR: begin
            mem_wr   = 1'b1;
            mem_addr = clr_ff;
         end
         pflr_pkg::ST_IDLE: begin
            busy          = 1'b0;
            line_ctl.load = start && (req_kind == pflr_pkg::KIND_LINE);
         end
         pflr_pkg::ST_LINE_PRIME: begin
            line_ctl.prime = 1'b1;
         end
         pflr_pkg::ST_LINE: begin
            mem_rd        = line_on;
            line_ctl.step = !line_on && !line_last;
         end
         pflr_pkg::ST_LINE_WR: begin
            mem_wr        = 1'b1;
            mem_wdata     = pflr_pkg::apply_pen(mem_rdata, line_mask, pen_ff);
            line_ctl.step = !line_last;
         end
         pflr_pkg::ST_RECT: begin
            mem_rd   = 1'b1;
            mem_addr = rect_addr;
         end
         pflr_pkg::ST_RECT_WR: begin
            mem_wr    = 1'b1;
            mem_addr  = rect_addr;
            mem_wdata = pflr_pkg::apply_pen(mem_rdata, rect_mask, pen_ff);
         end
         pflr_pkg::ST_READ: begin
            mem_rd   = read_ok;
            mem_addr = read_addr;
         end
         pflr_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if ((kind_ff == pflr_pkg::KIND_READ) && read_ok) begin
               rsp_read_data = mem_rdata;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      kind_in   = kind_ff;
      pen_in    = pen_ff;
      xa_in     = xa_ff;
      ya_in     = ya_ff;
      xb_in     = xb_ff;
      yb_in     = yb_ff;
      clr_in    = clr_ff;
      col_lo_in = col_lo_ff;
      col_hi_in = col_hi_ff;
      row_lo_in = row_lo_ff;
      row_hi_in = row_hi_ff;
      col_in    = col_ff;
      page_in   = page_ff;
      case (state_ff)
         pflr_pkg::ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
         end
         pflr_pkg::ST_IDLE: begin
            if (start) begin
               kind_in = req_kind;
               pen_in  = req_pen;
               xa_in   = req_x_a;
               ya_in   = req_y_a;
               xb_in   = req_x_b;
               yb_in   = req_y_b;
            end
         end
         pflr_pkg::ST_RECT_SETUP: begin
            col_lo_in = x_lo[COL_W-1:0];
            col_hi_in = x_hi[COL_W-1:0];
            row_lo_in = y_lo[ROW_W-1:0];
            row_hi_in = y_hi[ROW_W-1:0];
            col_in    = x_lo[COL_W-1:0];
            page_in   = y_lo[ROW_W-1:3];
         end
         pflr_pkg::ST_RECT_WR: begin
            if (col_ff == col_hi_ff) begin
               col_in  = col_lo_ff;
               page_in = page_ff + PAGE_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pflr_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      pen_ff    <= pen_in;
      xa_ff     <= xa_in;
      ya_ff     <= ya_in;
      xb_ff     <= xb_in;
      yb_ff     <= yb_in;
      col_lo_ff <= col_lo_in;
      col_hi_ff <= col_hi_in;
      row_lo_ff <= row_lo_in;
      row_hi_ff <= row_hi_in;
      col_ff    <= col_in;
      page_ff   <= page_in;
   end

endmodule

`default_nettype wire

[rtl/pflr_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module pflr_store #(
   parameter int DEPTH  = pflr_pkg::DEFAULT_SCREEN_WIDTH
                          * ((pflr_pkg::DEFAULT_SCREEN_HEIGHT + 7) / 8),
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             addr,
   input  wire logic [pflr_pkg::DATA_W-1:0]   wr_data,
   output logic      [pflr_pkg::DATA_W-1:0]   rd_data
);

   logic [pflr_pkg::DATA_W-1:0] store_ff [DEPTH];
   logic [pflr_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/pflr_line_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module pflr_line_step (
   input  wire logic                                 clock,
   input  wire pflr_pkg::line_ctl_type               ctl,
   input  wire logic signed [pflr_pkg::COORD_W-1:0]  x_a,
   input  wire logic signed [pflr_pkg::COORD_W-1:0]  y_a,
   input  wire logic signed [pflr_pkg::COORD_W-1:0]  x_b,
   input  wire logic signed [pflr_pkg::COORD_W-1:0]  y_b,
   output logic signed      [pflr_pkg::COORD_W-1:0]  cur_x,
   output logic signed      [pflr_pkg::COORD_W-1:0]  cur_y,
   output logic                                      last
);

   localparam int CW = pflr_pkg::COORD_W;
   localparam int EW = pflr_pkg::ERR_W;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, xe_ff, xe_in, ye_ff, ye_in;
   logic signed [EW-1:0] dx_ff, dx_in, dy_ff, dy_in, err_ff, err_in, dxy_ff, dxy_in;
   logic                 sx_ff, sx_in, sy_ff, sy_in;

   logic signed [CW:0]   diff_x, diff_y, abs_x, abs_y;
   logic signed [EW:0]   e2;
   logic                 go_x, go_y;
   logic signed [EW-1:0] err_add;

   always_comb begin
      diff_x  = $signed({x_b[CW-1], x_b}) - $signed({x_a[CW-1], x_a});
      diff_y  = $signed({y_b[CW-1], y_b}) - $signed({y_a[CW-1], y_a});
      abs_x   = diff_x[CW] ? -diff_x : diff_x;
      abs_y   = diff_y[CW] ? -diff_y : diff_y;
      e2      = $signed({err_ff, 1'b0});
      go_x    = e2 >= $signed({dy_ff[EW-1], dy_ff});
      go_y    = e2 <= $signed({dx_ff[EW-1], dx_ff});
      if (go_x && go_y) begin
         err_add = dxy_ff;
      end else if (go_x) begin
         err_add = dy_ff;
      end else if (go_y) begin
         err_add = dx_ff;
      end else begin
         err_add = '0;
      end

      x_in   = x_ff;
      y_in   = y_ff;
      xe_in  = xe_ff;
      ye_in  = ye_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      sx_in  = sx_ff;
      sy_in  = sy_ff;
      err_in = err_ff;
      dxy_in = dxy_ff;

      if (ctl.load) begin
         x_in  = x_a;
         y_in  = y_a;
         xe_in = x_b;
         ye_in = y_b;
         dx_in = EW'(abs_x);
         dy_in = -EW'(abs_y);
         sx_in = x_a < x_b;
         sy_in = y_a < y_b;
      end else if (ctl.prime) begin
         err_in = dx_ff + dy_ff;
         dxy_in = dx_ff + dy_ff;
      end else if (ctl.step) begin
         err_in = err_ff + err_add;
         if (go_x) begin
            x_in = sx_ff ? x_ff + 16'sd1 : x_ff - 16'sd1;
         end
         if (go_y) begin
            y_in = sy_ff ? y_ff + 16'sd1 : y_ff - 16'sd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      xe_ff  <= xe_in;
      ye_ff  <= ye_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      err_ff <= err_in;
      dxy_ff <= dxy_in;
   end

   assign cur_x = x_ff;
   assign cur_y = y_ff;
   assign last  = (x_ff == xe_ff) && (y_ff == ye_ff);

endmodule

`default_nettype wire

[tb/page_framebuffer_line_rect_engine_unit_tb.sv]
`timescale 1ns / 1ps

module page_framebuffer_line_rect_engine_unit_tb;

   localparam int CW = pflr_pkg::COORD_W;
   localparam int DW = pflr_pkg::DATA_W;
   localparam int SCR_W = pflr_pkg::DEFAULT_SCREEN_WIDTH;
   localparam int SCR_H = pflr_pkg::DEFAULT_SCREEN_HEIGHT;
   localparam int PAGES = (SCR_H + 7) / 8;
   localparam int STORE_BYTES = SCR_W * PAGES;
   localparam int RANDOM_WORDS = 1250;
   localparam int SETTLE_CYCLES = 40;
   localparam int LIMIT_CYCLES = 20_000_000;

   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [1:0] PEN_KEEP  = 2'd3;

   typedef struct packed {
      logic [1:0]           kind;
      logic signed [CW-1:0] x_a;
      logic signed [CW-1:0] y_a;
      logic signed [CW-1:0] x_b;
      logic signed [CW-1:0] y_b;
      logic [1:0]           pen;
      logic                 known;
      logic [DW-1:0]        known_data;
   } plan_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_kind = pflr_pkg::KIND_LINE;
   logic signed [CW-1:0] req_x_a = '0;
   logic signed [CW-1:0] req_y_a = '0;
   logic signed [CW-1:0] req_x_b = '0;
   logic signed [CW-1:0] req_y_b = '0;
   logic [1:0] req_pen = pflr_pkg::PEN_SET;
   logic rsp_valid;
   logic [DW-1:0] rsp_read_data;

   logic known_flag = 1'b0;
   logic [DW-1:0] known_data = '0;

   logic [DW-1:0] frame_img [STORE_BYTES];
   logic [DW-1:0] pending_read_data [$];
   plan_word_type plan [$];
   logic [DW-1:0] want;
   logic [DW-1:0] predicted;
   int mismatches = 0;
   int unsigned cycles = 0;

   page_framebuffer_line_rect_engine_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_x_a(req_x_a),
      .req_y_a(req_y_a),
      .req_x_b(req_x_b),
      .req_y_b(req_y_b),
      .req_pen(req_pen),
      .rsp_valid(rsp_valid),
      .rsp_read_data(rsp_read_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void paint(int x, int y, logic [1:0] pen);
      int at;
      logic [DW-1:0] mask;
      if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H) return;
      at = (y / 8) * SCR_W + x;
      mask = DW'(1) << (y % 8);
      case (pen)
         pflr_pkg::PEN_SET:   frame_img[at] = frame_img[at] | mask;
         pflr_pkg::PEN_CLEAR: frame_img[at] = frame_img[at] & ~mask;
         pflr_pkg::PEN_FLIP:  frame_img[at] = frame_img[at] ^ mask;
         default:   ;
      endcase
   endfunction

   function automatic void trace_line(int xa, int ya, int xb, int yb, logic [1:0] pen);
      int dx, dy, sx, sy, err, e2;
      dx = (xb > xa) ? xb - xa : xa - xb;
      dy = (yb > ya) ? ya - yb : yb - ya;
      sx = (xa < xb) ? 1 : -1;
      sy = (ya < yb) ? 1 : -1;
      err = dx + dy;
      forever begin
         paint(xa, ya, pen);
         if (xa == xb && ya == yb) break;
         e2 = 2 * err;
         if (e2 >= dy) begin
            err += dy;
            xa += sx;
         end
         if (e2 <= dx) begin
            err += dx;
            ya += sy;
         end
      end
   endfunction

   function automatic void fill_box(int x, int y, int w, int h, logic [1:0] pen);
      int lx, hx, ly, hy;
      lx = (x < 0) ? 0 : x;
      ly = (y < 0) ? 0 : y;
      hx = x + w - 1;
      hy = y + h - 1;
      if (hx > SCR_W - 1) hx = SCR_W - 1;
      if (hy > SCR_H - 1) hy = SCR_H - 1;
      if (lx > hx || ly > hy) return;
      for (int j = ly; j <= hy; j++)
         for (int i = lx; i <= hx; i++)
            paint(i, j, pen);
   endfunction

   function automatic logic [DW-1:0] apply_command(logic [1:0] kind, int xa, int ya,
                                                   int xb, int yb, logic [1:0] pen);
      logic [DW-1:0] data;
      data = '0;
      case (kind)
         pflr_pkg::KIND_LINE: trace_line(xa, ya, xb, yb, pen);
         pflr_pkg::KIND_RECT: fill_box(xa, ya, xb, yb, pen);
         pflr_pkg::KIND_READ: begin
            if (xa >= 0 && xa < SCR_W && ya >= 0 && ya < PAGES)
               data = frame_img[ya * SCR_W + xa];
         end
         default: ;
      endcase
      return data;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (pending_read_data.size() == 0) begin
               $error("rsp_read_data: expected nothing, got %02h", rsp_read_data);
               mismatches++;
            end else begin
               want = pending_read_data.pop_front();
               if (rsp_read_data !== want) begin
                  $error("rsp_read_data: expected %02h, got %02h", want, rsp_read_data);
                  mismatches++;
               end
            end
         end
         if (start && busy === 1'b0) begin
            predicted = apply_command(req_kind, req_x_a, req_y_a, req_x_b, req_y_b, req_pen);
            pending_read_data.push_back(known_flag ? known_data : predicted);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int span(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic int wide();
      return int'($signed(16'($urandom())));
   endfunction

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   task automatic plan_add(logic [1:0] kind, int xa, int ya, int xb, int yb,
                           logic [1:0] pen, logic known, logic [DW-1:0] data);
      plan_word_type w;
      w.kind = kind;
      w.x_a = 16'(xa);
      w.y_a = 16'(ya);
      w.x_b = 16'(xb);
      w.y_b = 16'(yb);
      w.pen = pen;
      w.known = known;
      w.known_data = data;
      plan.push_back(w);
   endtask

   function automatic plan_word_type random_word();
      plan_word_type w;
      int pick, xa, ya, xb, yb;
      pick = span(0, 99);
      w = '0;
      w.pen = 2'($urandom_range(3));
      if (pick < 35) begin
         w.kind = pflr_pkg::KIND_LINE;
         if (span(0, 9) == 0) begin
            xa = wide();
            ya = wide();
            xb = clamp16(xa + span(-40, 40));
            yb = clamp16(ya + span(-40, 40));
         end else begin
            xa = span(-16, SCR_W + 15);
            ya = span(-16, SCR_H + 15);
            xb = span(-16, SCR_W + 15);
            yb = span(-16, SCR_H + 15);
         end
      end else if (pick < 60) begin
         w.kind = pflr_pkg::KIND_RECT;
         xa = span(-16, SCR_W + 7);
         ya = span(-16, SCR_H + 7);
         xb = span(-4, 48);
         yb = span(-4, 40);
         if (span(0, 9) == 0) begin
            xa = wide();
            ya = wide();
            xb = wide();
            yb = wide();
         end else if (span(0, 29) == 0) begin
            xa = span(-8, 0);
            ya = span(-8, 0);
            xb = span(SCR_W + 8, SCR_W * 2);
            yb = span(SCR_H + 8, SCR_H * 2);
         end
      end else if (pick < 95) begin
         w.kind = pflr_pkg::KIND_READ;
         xa = span(-2, SCR_W + 1);
         ya = span(-1, PAGES);
         xb = wide();
         yb = wide();
         if (span(0, 9) == 0) begin
            xa = wide();
            ya = wide();
         end
      end else begin
         w.kind = KIND_NONE;
         xa = wide();
         ya = wide();
         xb = wide();
         yb = wide();
      end
      w.x_a = 16'(xa);
      w.y_a = 16'(ya);
      w.x_b = 16'(xb);
      w.y_b = 16'(yb);
      return w;
   endfunction

   task automatic send_word(plan_word_type w);
      start <= 1'b1;
      req_kind <= w.kind;
      req_x_a <= w.x_a;
      req_y_a <= w.y_a;
      req_x_b <= w.x_b;
      req_y_b <= w.y_b;
      req_pen <= w.pen;
      known_flag <= w.known;
      known_data <= w.known_data;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic idle_after(logic quiet);
      int r, n;
      r = span(0, 99);
      n = 0;
      if (!quiet) begin
         if (r >= 92) n = span(8, 60);
         else if (r >= 55) n = span(1, 3);
      end
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_read_data.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic quiet;
      foreach (frame_img[i]) frame_img[i] = '0;

      // Reads right after reset and every out-of-range read give zero.
      plan_add(pflr_pkg::KIND_READ, 0, 0, 0, 0, pflr_pkg::PEN_SET, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_READ, SCR_W - 1, PAGES - 1, 0, 0, pflr_pkg::PEN_SET, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_READ, -1, 0, 0, 0, pflr_pkg::PEN_SET, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_READ, SCR_W, 0, 0, 0, pflr_pkg::PEN_SET, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_READ, 0, PAGES, 0, 0, pflr_pkg::PEN_SET, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_READ, 0, -1, 0, 0, pflr_pkg::PEN_SET, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_READ, 32767, 32767, 32767, 32767, PEN_KEEP, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_READ, -32768, -32768, -32768, -32768, pflr_pkg::PEN_FLIP,
               1'b1, 8'h00);
      plan_add(KIND_NONE, -32768, 32767, -32768, 32767, pflr_pkg::PEN_FLIP, 1'b1, 8'h00);
      // Draw commands always return a zero word.
      plan_add(pflr_pkg::KIND_LINE, 0, 0, SCR_W - 1, SCR_H - 1, pflr_pkg::PEN_SET,
               1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_READ, 0, 0, 0, 0, pflr_pkg::PEN_SET, 1'b0, 8'h00);
      plan_add(pflr_pkg::KIND_READ, SCR_W - 1, PAGES - 1, 0, 0, pflr_pkg::PEN_SET, 1'b0, 8'h00);
      plan_add(pflr_pkg::KIND_RECT, -32768, -32768, 32767, 32767, pflr_pkg::PEN_SET,
               1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_RECT, 10, 8, 0, 5, pflr_pkg::PEN_SET, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_RECT, 10, 8, -5, -5, pflr_pkg::PEN_SET, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_RECT, SCR_W - 8, SCR_H - 4, 32767, 32767, pflr_pkg::PEN_FLIP,
               1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_RECT, -5, -5, SCR_W + 72, SCR_H + 36, pflr_pkg::PEN_FLIP,
               1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_READ, 10, 1, 0, 0, pflr_pkg::PEN_SET, 1'b0, 8'h00);
      plan_add(pflr_pkg::KIND_LINE, -32768, -32768, 32767, 32767, pflr_pkg::PEN_CLEAR,
               1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_LINE, 32767, 3, -32768, 20, pflr_pkg::PEN_FLIP, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_LINE, 5, -32768, 5, 32767, pflr_pkg::PEN_SET, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_LINE, 3, 3, 3, 3, pflr_pkg::PEN_FLIP, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_LINE, 40, 10, 60, 50, PEN_KEEP, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_READ, 5, 4, 0, 0, pflr_pkg::PEN_SET, 1'b0, 8'h00);
      plan_add(pflr_pkg::KIND_RECT, 0, 0, SCR_W, SCR_H, pflr_pkg::PEN_CLEAR, 1'b1, 8'h00);
      plan_add(pflr_pkg::KIND_READ, 64, 4, 0, 0, pflr_pkg::PEN_SET, 1'b1, 8'h00);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_word(plan[i]);
         idle_after(1'b0);
      end

      quiet = 1'b0;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 100 == 0) quiet = (span(0, 3) == 0);
         if (i == RANDOM_WORDS / 2) drain();
         send_word(random_word());
         idle_after(quiet);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/pflr_pkg.sv
rtl/pflr_store.sv
rtl/pflr_line_step.sv
rtl/page_framebuffer_line_rect_engine_unit.sv
tb/page_framebuffer_line_rect_engine_unit_tb.sv
